FILE: rtl/core/tchs_pkg.sv
// Shared types and codes of the TLS ClientHello sniffer.
`default_nettype none
package tchs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_ALPN    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [3:0] VD_PARSED     = 4'd0;
    localparam logic [3:0] VD_SSLV2      = 4'd1;
    localparam logic [3:0] VD_NOT_HS     = 4'd2;
    localparam logic [3:0] VD_BAD_VER    = 4'd3;
    localparam logic [3:0] VD_NOT_HELLO  = 4'd4;
    localparam logic [3:0] VD_SNI_NOTDNS = 4'd5;
    localparam logic [3:0] VD_SNI_FORMAT = 4'd6;
    localparam logic [3:0] VD_ALPN_EMPTY = 4'd7;
    localparam logic [3:0] VD_ALPN_FMT   = 4'd8;
    localparam logic [3:0] VD_LENGTH     = 4'd9;
    localparam logic [3:0] VD_DISABLED   = 4'd10;

    localparam logic [7:0]  REC_HANDSHAKE = 8'h16;
    localparam logic [7:0]  SSL2_MARK     = 8'h80;
    localparam logic [7:0]  EXT_SUPVER    = 8'd43;
    localparam logic [7:0]  EXT_ALPN      = 8'd16;
    localparam logic [7:0]  ALPN_COMMA    = 8'h2c;
    localparam logic [15:0] TLS13_VERSION = 16'h0304;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       conn_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic [3:0] verdict;
        logic [7:0] version_major;
        logic [7:0] version_minor;
    } result_t;

    typedef struct packed {
        result_t res;
        logic    last;
    } out_item_t;

    // Push request from the parser into the result queue.
    typedef struct packed {
        logic      wr0;
        logic      wr1;
        out_item_t item0;
        out_item_t item1;
    } push_t;

endpackage
`default_nettype wire

FILE: rtl/core/tls_client_hello_sniffer_top.sv
// Top level of the TLS ClientHello sniffer: input queue, parser, result queue.
//
// Usage: connection bytes enter on the in channel (in_valid/in_ready) with
// conn_start set on the first byte of each connection. The block checks the
// TLS record headers, walks the ClientHello and streams out the first SNI
// host name (kind 0) and the first ALPN list (kind 1, commas between
// protocols), followed by one verdict (kind 2) carrying the client version.
// Each byte causes zero, one or two results; last marks the final one.
// Bytes after the verdict produce nothing until the next conn_start.
// The user must write the enable register through enable_we/enable_wdata
// only while idle; the block does not enforce this. Throughput: one byte per
// cycle inside a field while the result queue has room for two. At a field's
// end the parser takes a step with no byte, plus one per zero-length field
// it steps over. A byte is registered in the input queue and its results in
// the result queue before the out channel offers them; those steps can delay
// them. When the receiver stalls, results wait in a four-entry queue; the
// parser pauses while fewer than two entries are free, and the four-entry
// input queue keeps taking bytes until it fills.
// Reset clears both queues, the parser state and the enable register.
`default_nettype none
module tls_client_hello_sniffer_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       enable_we,
    input  wire logic       enable_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       conn_start,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      value,
    output logic [3:0]      verdict,
    output logic [7:0]      version_major,
    output logic [7:0]      version_minor,
    output logic            last
);
    import tchs_pkg::*;

    in_item_t  in_item;
    in_item_t  head_item;
    logic      head_valid;
    logic      pop;
    logic      room2;
    push_t     push;
    out_item_t out_item;

    assign in_item.data_byte  = data_byte;
    assign in_item.conn_start = conn_start;

    // Front end: holds accepted bytes so the parser can stall on its own.
    tchs_in_queue u_in_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop)
    );

    // Back end: record and hello state machine.
    tchs_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable_we    (enable_we),
        .enable_wdata (enable_wdata),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .room2        (room2),
        .push         (push)
    );

    // Result queue decouples the parser from the downstream receiver.
    tchs_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head_item (out_item)
    );

    assign kind          = out_item.res.kind;
    assign value         = out_item.res.value;
    assign verdict       = out_item.res.verdict;
    assign version_major = out_item.res.version_major;
    assign version_minor = out_item.res.version_minor;
    assign last          = out_item.last;

endmodule
`default_nettype wire

FILE: rtl/core/tchs_in_queue.sv
// Input queue: accepts connection bytes and holds them for the parser.
`default_nettype none
module tchs_in_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tchs_pkg::in_item_t in_item,
    output logic                   head_valid,
    output tchs_pkg::in_item_t     head_item,
    input  wire logic              pop
);
    import tchs_pkg::*;

    in_item_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                push;
    logic                do_pop;

    assign in_ready   = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_item  = mem[rptr_reg];
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tchs_out_queue.sv
// Result queue: takes up to two results per cycle, delivers one per transfer.
`default_nettype none
module tchs_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tchs_pkg::push_t   push,
    output logic                   room2,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tchs_pkg::out_item_t    head_item
);
    import tchs_pkg::*;

    out_item_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_pop;
    logic [QCNT_W-1:0]   n_push;

    assign room2     = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign head_item = mem[rptr_reg];
    assign do_pop    = out_valid && out_ready;
    assign n_push    = QCNT_W'(push.wr0) + QCNT_W'(push.wr0 && push.wr1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_reg + QPTR_W'(n_push);
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + n_push - QCNT_W'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.wr0)
        begin
            mem[wptr_reg] <= push.item0;
            if (push.wr1)
            begin
                mem[wptr_reg + QPTR_W'(1)] <= push.item1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tchs_parser.sv
// Parser back end: record header checks and the ClientHello field walk.
`default_nettype none
module tchs_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               enable_we,
    input  wire logic               enable_wdata,
    input  wire logic               head_valid,
    input  wire tchs_pkg::in_item_t head_item,
    output logic                    pop,
    input  wire logic               room2,
    output tchs_pkg::push_t         push
);
    import tchs_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_BODY = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [4:0] {
        HS_START           = 5'd0,
        HS_HEADER          = 5'd1,
        HS_VERSION         = 5'd2,
        HS_RANDOM          = 5'd3,
        HS_SID_LEN         = 5'd4,
        HS_SID             = 5'd5,
        HS_CS_LEN          = 5'd6,
        HS_CS              = 5'd7,
        HS_CM_LEN          = 5'd8,
        HS_CM              = 5'd9,
        HS_EXT             = 5'd10,
        HS_EXT_HEADER      = 5'd11,
        HS_SNI_LEN         = 5'd12,
        HS_SNI_HOST_HEAD   = 5'd13,
        HS_SNI_HOST        = 5'd14,
        HS_ALPN_LEN        = 5'd15,
        HS_ALPN_PROTO_LEN  = 5'd16,
        HS_ALPN_PROTO_DATA = 5'd17,
        HS_SUPVER_LEN      = 5'd18
    } hs_t;

    // Results collected for the byte in flight; at most two survive.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } step_buf_t;

    function automatic step_buf_t buf_add(step_buf_t sb, result_t r);
        step_buf_t o;
        o = sb;
        case (sb.cnt)
            2'd0:
            begin
                o.r0  = r;
                o.cnt = 2'd1;
            end
            2'd1:
            begin
                o.r1  = r;
                o.cnt = 2'd2;
            end
            default:
            begin
                if (r.kind == KIND_VERDICT)
                begin
                    o.r1 = r;
                end
            end
        endcase
        return o;
    endfunction

    logic        enable_reg;
    phase_t      phase_reg, phase_next;
    logic [31:0] rec_hdr_reg, rec_hdr_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [15:0] rec_rem_reg, rec_rem_next;
    hs_t         hs_reg, hs_next;
    logic [15:0] fsize_reg, fsize_next;
    logic [23:0] msg_left_reg, msg_left_next;
    logic [15:0] list_left_reg, list_left_next;
    logic [31:0] scratch_reg, scratch_next;
    logic [1:0]  sidx_reg, sidx_next;
    logic [15:0] cv_reg, cv_next;
    logic        name_seen_reg, name_seen_next;
    logic        alpn_seen_reg, alpn_seen_next;
    logic        adv_reg, adv_next;
    step_buf_t   sb_reg, sb_next;

    logic        verd_v;
    logic [3:0]  verd_code;
    logic        byte_v;
    result_t     byte_res;
    logic        comma_v;
    logic        step_end;
    logic        trans;
    logic [7:0]  b;
    logic [7:0]  p0, p1, p2, p3;
    logic [7:0]  s0, s1, s2, s3;
    logic [16:0] need;
    result_t     vres;

    assign pop   = !adv_reg && head_valid && room2;
    assign trans = adv_reg && room2;
    assign b     = head_item.data_byte;
    assign s0    = scratch_reg[7:0];
    assign s1    = scratch_reg[15:8];
    assign s2    = scratch_reg[23:16];
    assign s3    = scratch_reg[31:24];

    always_comb
    begin
        phase_next     = phase_reg;
        rec_hdr_next   = rec_hdr_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        rec_rem_next   = rec_rem_reg;
        hs_next        = hs_reg;
        fsize_next     = fsize_reg;
        msg_left_next  = msg_left_reg;
        list_left_next = list_left_reg;
        scratch_next   = scratch_reg;
        sidx_next      = sidx_reg;
        cv_next        = cv_reg;
        name_seen_next = name_seen_reg;
        alpn_seen_next = alpn_seen_reg;
        adv_next       = adv_reg;
        verd_v         = 1'b0;
        verd_code      = VD_PARSED;
        byte_v         = 1'b0;
        byte_res       = '0;
        comma_v        = 1'b0;
        step_end       = 1'b0;
        need           = '0;
        p0 = rec_hdr_reg[7:0];
        p1 = rec_hdr_reg[15:8];
        p2 = rec_hdr_reg[23:16];
        p3 = rec_hdr_reg[31:24];

        if (pop)
        begin
            if (head_item.conn_start)
            begin
                phase_next     = PH_HDR;
                rec_hdr_next   = '0;
                hdr_cnt_next   = '0;
                rec_rem_next   = '0;
                hs_next        = HS_START;
                fsize_next     = '0;
                msg_left_next  = '0;
                list_left_next = '0;
                scratch_next   = '0;
                sidx_next      = '0;
                cv_next        = '0;
                name_seen_next = 1'b0;
                alpn_seen_next = 1'b0;
            end
            if (phase_next == PH_DONE)
            begin
                step_end = 1'b1;
            end
            else if (!enable_reg)
            begin
                verd_v    = 1'b1;
                verd_code = VD_DISABLED;
            end
            else if (phase_next == PH_HDR)
            begin
                if (hdr_cnt_next < 3'd4)
                begin
                    if (hdr_cnt_next == 3'd0)
                    begin
                        rec_hdr_next = {24'd0, b};
                    end
                    else
                    begin
                        rec_hdr_next[{hdr_cnt_next[1:0], 3'b000} +: 8] = b;
                    end
                    hdr_cnt_next = hdr_cnt_next + 3'd1;
                    step_end     = 1'b1;
                end
                else
                begin
                    hdr_cnt_next = '0;
                    p0 = rec_hdr_next[7:0];
                    p1 = rec_hdr_next[15:8];
                    p2 = rec_hdr_next[23:16];
                    p3 = rec_hdr_next[31:24];
                    if (((p0 & SSL2_MARK) != 8'd0) && p2 == 8'd1
                        && (p3 == 8'd0 || p3 == 8'd3))
                    begin
                        cv_next   = {p3, b};
                        verd_v    = 1'b1;
                        verd_code = VD_SSLV2;
                    end
                    else if (p0 != REC_HANDSHAKE)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_NOT_HS;
                    end
                    else if (p1 != 8'd3)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_BAD_VER;
                    end
                    else
                    begin
                        rec_rem_next = {p3, b};
                        phase_next   = (rec_rem_next != 16'd0) ? PH_BODY : PH_HDR;
                        if (fsize_next == 16'd0)
                        begin
                            adv_next = 1'b1;
                        end
                        else
                        begin
                            step_end = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                case (hs_next)
                    HS_HEADER, HS_SID_LEN, HS_CS_LEN, HS_CM_LEN, HS_EXT_HEADER,
                    HS_SNI_LEN, HS_SNI_HOST_HEAD, HS_ALPN_LEN, HS_ALPN_PROTO_LEN,
                    HS_SUPVER_LEN:
                    begin
                        scratch_next[{sidx_next, 3'b000} +: 8] = b;
                        sidx_next = sidx_next + 2'd1;
                    end
                    HS_VERSION:
                    begin
                        if (fsize_next == 16'd2)
                        begin
                            cv_next[15:8] = b;
                        end
                        else
                        begin
                            cv_next[7:0] = b;
                        end
                    end
                    HS_SNI_HOST:
                    begin
                        byte_v         = 1'b1;
                        byte_res.kind  = KIND_NAME;
                        byte_res.value = b;
                    end
                    HS_ALPN_PROTO_DATA:
                    begin
                        byte_v         = 1'b1;
                        byte_res.kind  = KIND_ALPN;
                        byte_res.value = b;
                    end
                    default:
                    begin
                    end
                endcase
                if (fsize_next != 16'd0)
                begin
                    fsize_next = fsize_next - 16'd1;
                    if (msg_left_next != 24'd0)
                    begin
                        msg_left_next = msg_left_next - 24'd1;
                    end
                end
                // Record accounting is independent of the field walk.
                rec_rem_next = rec_rem_next - 16'd1;
                if (rec_rem_next == 16'd0)
                begin
                    phase_next   = PH_HDR;
                    hdr_cnt_next = '0;
                end
                if (fsize_next == 16'd0)
                begin
                    adv_next = 1'b1;
                end
                else
                begin
                    step_end = 1'b1;
                end
            end
        end
        else if (trans)
        begin
            case (hs_reg)
                HS_START:
                begin
                    hs_next       = HS_HEADER;
                    fsize_next    = 16'd4;
                    sidx_next     = '0;
                    msg_left_next = 24'd4;
                end
                HS_HEADER:
                begin
                    if (s0 != 8'd1)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_NOT_HELLO;
                    end
                    else
                    begin
                        hs_next       = HS_VERSION;
                        fsize_next    = 16'd2;
                        msg_left_next = {s1, s2, s3};
                    end
                end
                HS_VERSION:
                begin
                    hs_next    = HS_RANDOM;
                    fsize_next = 16'd32;
                end
                HS_RANDOM:
                begin
                    hs_next    = HS_SID_LEN;
                    fsize_next = 16'd1;
                    sidx_next  = '0;
                end
                HS_SID_LEN:
                begin
                    hs_next    = HS_SID;
                    fsize_next = {8'd0, s0};
                end
                HS_SID:
                begin
                    hs_next    = HS_CS_LEN;
                    fsize_next = 16'd2;
                    sidx_next  = '0;
                end
                HS_CS_LEN:
                begin
                    hs_next    = HS_CS;
                    fsize_next = {s0, s1};
                end
                HS_CS:
                begin
                    hs_next    = HS_CM_LEN;
                    fsize_next = 16'd1;
                    sidx_next  = '0;
                end
                HS_CM_LEN:
                begin
                    hs_next    = HS_CM;
                    fsize_next = {8'd0, s0};
                end
                HS_CM, HS_EXT:
                begin
                    if (msg_left_reg == 24'd0)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_PARSED;
                    end
                    else if (hs_reg == HS_CM)
                    begin
                        hs_next    = HS_EXT;
                        fsize_next = 16'd2;
                    end
                    else
                    begin
                        hs_next    = HS_EXT_HEADER;
                        fsize_next = 16'd4;
                        sidx_next  = '0;
                    end
                end
                HS_EXT_HEADER:
                begin
                    if (s0 == 8'd0 && s1 == 8'd0 && !name_seen_reg)
                    begin
                        hs_next    = HS_SNI_LEN;
                        fsize_next = 16'd2;
                        sidx_next  = '0;
                    end
                    else if (s0 == 8'd0 && s1 == EXT_ALPN && !alpn_seen_reg)
                    begin
                        hs_next    = HS_ALPN_LEN;
                        fsize_next = 16'd2;
                        sidx_next  = '0;
                    end
                    else if (s0 == 8'd0 && s1 == EXT_SUPVER)
                    begin
                        hs_next    = HS_SUPVER_LEN;
                        fsize_next = 16'd1;
                        sidx_next  = '0;
                    end
                    else
                    begin
                        hs_next    = HS_EXT;
                        fsize_next = {s2, s3};
                    end
                end
                HS_SNI_LEN:
                begin
                    list_left_next = {s0, s1};
                    hs_next        = HS_SNI_HOST_HEAD;
                    fsize_next     = 16'd3;
                    sidx_next      = '0;
                end
                HS_SNI_HOST_HEAD:
                begin
                    need = 17'd3 + {1'b0, s1, s2};
                    if (s0 != 8'd0)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_SNI_NOTDNS;
                    end
                    else if ({1'b0, list_left_reg} < need)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_SNI_FORMAT;
                    end
                    else
                    begin
                        list_left_next = list_left_reg - need[15:0];
                        name_seen_next = 1'b1;
                        hs_next        = HS_SNI_HOST;
                        fsize_next     = {s1, s2};
                    end
                end
                HS_SNI_HOST:
                begin
                    hs_next    = HS_EXT;
                    fsize_next = list_left_reg;
                end
                HS_ALPN_LEN:
                begin
                    list_left_next = {s0, s1};
                    alpn_seen_next = 1'b1;
                    hs_next        = HS_ALPN_PROTO_LEN;
                    fsize_next     = 16'd1;
                    sidx_next      = '0;
                end
                HS_ALPN_PROTO_LEN:
                begin
                    need = 17'd1 + {9'd0, s0};
                    if (s0 == 8'd0)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_ALPN_EMPTY;
                    end
                    else if ({1'b0, list_left_reg} < need)
                    begin
                        verd_v    = 1'b1;
                        verd_code = VD_ALPN_FMT;
                    end
                    else
                    begin
                        list_left_next = list_left_reg - need[15:0];
                        hs_next        = HS_ALPN_PROTO_DATA;
                        fsize_next     = {8'd0, s0};
                    end
                end
                HS_ALPN_PROTO_DATA:
                begin
                    if (list_left_reg != 16'd0)
                    begin
                        comma_v    = 1'b1;
                        hs_next    = HS_ALPN_PROTO_LEN;
                        fsize_next = 16'd1;
                        sidx_next  = '0;
                    end
                    else
                    begin
                        hs_next    = HS_EXT;
                        fsize_next = 16'd0;
                    end
                end
                HS_SUPVER_LEN:
                begin
                    cv_next    = TLS13_VERSION;
                    hs_next    = HS_EXT;
                    fsize_next = {8'd0, s0};
                end
                default:
                begin
                    verd_v    = 1'b1;
                    verd_code = VD_LENGTH;
                end
            endcase
            if (!verd_v)
            begin
                if (msg_left_next < {8'd0, fsize_next})
                begin
                    verd_v    = 1'b1;
                    verd_code = VD_LENGTH;
                end
                else if (fsize_next != 16'd0)
                begin
                    adv_next = 1'b0;
                    step_end = 1'b1;
                end
            end
        end

        if (verd_v)
        begin
            phase_next = PH_DONE;
            adv_next   = 1'b0;
            step_end   = 1'b1;
        end

        vres               = '0;
        vres.kind          = KIND_VERDICT;
        vres.verdict       = verd_code;
        vres.version_major = cv_next[15:8];
        vres.version_minor = cv_next[7:0];

        sb_next = sb_reg;
        if (byte_v)
        begin
            sb_next = buf_add(sb_next, byte_res);
        end
        if (comma_v)
        begin
            sb_next = buf_add(sb_next, '{kind: KIND_ALPN, value: ALPN_COMMA,
                                         verdict: 4'd0, version_major: 8'd0,
                                         version_minor: 8'd0});
        end
        if (verd_v)
        begin
            sb_next = buf_add(sb_next, vres);
        end

        push            = '0;
        push.item0.res  = sb_next.r0;
        push.item0.last = (sb_next.cnt == 2'd1);
        push.item1.res  = sb_next.r1;
        push.item1.last = 1'b1;
        if (step_end)
        begin
            push.wr0    = (sb_next.cnt != 2'd0);
            push.wr1    = (sb_next.cnt == 2'd2);
            sb_next.cnt = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            phase_reg     <= PH_HDR;
            rec_hdr_reg   <= '0;
            hdr_cnt_reg   <= '0;
            rec_rem_reg   <= '0;
            hs_reg        <= HS_START;
            fsize_reg     <= '0;
            msg_left_reg  <= '0;
            list_left_reg <= '0;
            scratch_reg   <= '0;
            sidx_reg      <= '0;
            cv_reg        <= '0;
            name_seen_reg <= 1'b0;
            alpn_seen_reg <= 1'b0;
            adv_reg       <= 1'b0;
            sb_reg        <= '0;
        end
        else
        begin
            if (enable_we)
            begin
                enable_reg <= enable_wdata;
            end
            phase_reg     <= phase_next;
            rec_hdr_reg   <= rec_hdr_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            rec_rem_reg   <= rec_rem_next;
            hs_reg        <= hs_next;
            fsize_reg     <= fsize_next;
            msg_left_reg  <= msg_left_next;
            list_left_reg <= list_left_next;
            scratch_reg   <= scratch_next;
            sidx_reg      <= sidx_next;
            cv_reg        <= cv_next;
            name_seen_reg <= name_seen_next;
            alpn_seen_reg <= alpn_seen_next;
            adv_reg       <= adv_next;
            sb_reg        <= sb_next;
        end
    end

endmodule
`default_nettype wire
